@@ hw/rtl/lcg_keystream_header_cipher_macros.svh @@
// Assertion macros for the checker file of the cipher block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LCG_KEYSTREAM_HEADER_CIPHER_MACROS_SVH
`define LCG_KEYSTREAM_HEADER_CIPHER_MACROS_SVH

// Property checked at every edge outside reset.
`define LCGK_ASSERT_ACTIVE(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LCGK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lcgk_pkg.sv @@
`default_nettype none

package lcgk_pkg;

  localparam logic [30:0] KeyMult   = 31'd48271;
  localparam logic [30:0] KeyMod    = 31'h7FFF_FFFF;
  localparam logic [8:0]  StreamMod = 9'hFF;
  localparam logic [5:0]  RecLen    = 6'h28;
  localparam logic [5:0]  OffStart  = 6'h20;
  localparam logic [5:0]  SizeStart = 6'h24;
  localparam logic [5:0]  RecLast   = RecLen - 6'd1;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_SIZE   = 2'd2
  } field_kind_t;

  // Handshake decisions that the top level hands to the datapath units.
  typedef struct packed {
    logic advance;
    logic restart;
  } step_ctrl_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [5:0]  byte_position;
    field_kind_t field_kind;
    logic        name_char_valid;
    logic        record_done;
    logic [31:0] entry_offset;
    logic [31:0] entry_size;
  } result_t;

  // Multiply by 48271 modulo 2^31-1. The high part of the product folds
  // back onto the low part because 2^31 is congruent to 1. A residue of
  // zero only comes from a key of 0 or 2^31-1, and both map to 2^31-1.
  function automatic logic [30:0] key_advance(input logic [30:0] k);
    logic [46:0] prod;
    logic [31:0] fold;
    logic [31:0] red;
    prod = 47'(k) * 47'(KeyMult);
    fold = 32'(prod[46:31]) + 32'(prod[30:0]);
    red  = (fold >= 32'(KeyMod)) ? fold - 32'(KeyMod) : fold;
    return (red == 32'd0) ? KeyMod : red[30:0];
  endfunction

  // Key modulo 255: 256 is congruent to 1, so the bytes are summed and folded.
  function automatic logic [7:0] key_mod255(input logic [30:0] k);
    logic [9:0] sum;
    logic [8:0] fold;
    sum  = 10'(k[7:0]) + 10'(k[15:8]) + 10'(k[23:16]) + 10'(k[30:24]);
    fold = 9'(sum[7:0]) + 9'(sum[9:8]);
    return (fold >= StreamMod) ? 8'(fold - StreamMod) : fold[7:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lcgk_item_if.sv @@
`default_nettype none

interface lcgk_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, data_byte, restart, input ready);
  modport sink (input valid, data_byte, restart, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lcgk_result_if.sv @@
`default_nettype none

interface lcgk_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [5:0]  byte_position;
  logic [1:0]  field_kind;
  logic        name_char_valid;
  logic        record_done;
  logic [31:0] entry_offset;
  logic [31:0] entry_size;

  modport source (output valid, out_byte, byte_position, field_kind, name_char_valid,
                  record_done, entry_offset, entry_size, input ready);
  modport sink (input valid, out_byte, byte_position, field_kind, name_char_valid,
                record_done, entry_offset, entry_size, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lcgk_cfg_if.sv @@
`default_nettype none

interface lcgk_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] seed;

  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lcg_keystream_header_cipher.sv @@
`default_nettype none

// Channel  Role    Payload                                   Transfer
// item     sink    data_byte[7:0], restart                   valid & ready
// result   source  out_byte, byte_position, field_kind,      valid & ready
//                  name_char_valid, record_done,
//                  entry_offset, entry_size
// cfg      sink    seed[15:0]                                valid & ready
//
// One byte is taken every cycle unless the result stalls, and is registered
// at the input and again at the result. The loop that sets the rate is the key
// register with its multiply-and-fold update, which completes once per cycle.
// Reset (synchronous) clears the key, record position, accumulators and seed.
// A stalled result holds; the input register still takes one byte meanwhile.
// cfg is always ready.

module lcg_keystream_header_cipher (
  input wire logic       clk,
  input wire logic       rst,
  lcgk_item_if.sink      item,
  lcgk_result_if.source  result,
  lcgk_cfg_if.sink       cfg
);
  import lcgk_pkg::*;

  logic       in_valid;
  logic [7:0] in_data;
  logic       in_restart;
  logic       res_valid;
  result_t    res;
  result_t    res_comb;
  logic [15:0] seed;
  logic [7:0] stream_byte;
  step_ctrl_t ctrl;

  assign ctrl.advance = in_valid && (!res_valid || result.ready);
  assign ctrl.restart = in_restart;
  assign item.ready   = !in_valid || ctrl.advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg.valid) begin
      seed <= cfg.seed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (ctrl.advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_data    <= item.data_byte;
      in_restart <= item.restart;
    end
  end

  lcgk_keygen u_keygen (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .seed        (seed),
    .stream_byte (stream_byte)
  );

  lcgk_record u_record (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .out_byte (in_data ^ stream_byte),
    .res      (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      res <= res_comb;
    end
  end

  assign result.valid           = res_valid;
  assign result.out_byte        = res.out_byte;
  assign result.byte_position   = res.byte_position;
  assign result.field_kind      = res.field_kind;
  assign result.name_char_valid = res.name_char_valid;
  assign result.record_done     = res.record_done;
  assign result.entry_offset    = res.entry_offset;
  assign result.entry_size      = res.entry_size;

endmodule

`default_nettype wire

@@ hw/rtl/lcgk_keygen.sv @@
`default_nettype none

module lcgk_keygen (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lcgk_pkg::step_ctrl_t ctrl,
  input  wire logic [15:0]        seed,
  output logic [7:0]              stream_byte
);
  import lcgk_pkg::*;

  logic [30:0] key;
  logic [30:0] key_next;
  logic [30:0] key_base;

  // A restart reloads the key before the byte is processed.
  assign key_base    = ctrl.restart ? 31'(seed) : key;
  assign key_next    = key_advance(key_base);
  assign stream_byte = key_mod255(key_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (ctrl.advance) begin
      key <= key_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lcgk_record.sv @@
`default_nettype none

module lcgk_record (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lcgk_pkg::step_ctrl_t ctrl,
  input  wire logic [7:0]           out_byte,
  output lcgk_pkg::result_t         res
);
  import lcgk_pkg::*;

  logic [5:0]  position;
  logic [5:0]  position_next;
  logic [31:0] offset_acc;
  logic [31:0] offset_acc_next;
  logic [23:0] size_acc;
  logic [23:0] size_acc_next;
  logic [5:0]  pos;
  logic [31:0] offset_base;
  logic [23:0] size_base;
  logic        done;
  field_kind_t kind;

  always_comb begin
    pos         = (ctrl.restart || position >= RecLen) ? 6'd0 : position;
    offset_base = ctrl.restart ? 32'd0 : offset_acc;
    size_base   = ctrl.restart ? 24'd0 : size_acc;
    done        = (pos == RecLast);

    offset_acc_next = offset_base;
    size_acc_next   = size_base;
    if (pos < OffStart) begin
      kind = KIND_NAME;
    end else if (pos < SizeStart) begin
      kind = KIND_OFFSET;
      // Offset bytes start on a multiple of four, so the low bits pick the lane.
      case (pos[1:0])
        2'd0:    offset_acc_next[7:0]   = out_byte;
        2'd1:    offset_acc_next[15:8]  = out_byte;
        2'd2:    offset_acc_next[23:16] = out_byte;
        default: offset_acc_next[31:24] = out_byte;
      endcase
    end else begin
      kind = KIND_SIZE;
      // The top size byte goes straight to the result on the last byte.
      case (pos[1:0])
        2'd0:    size_acc_next[7:0]   = out_byte;
        2'd1:    size_acc_next[15:8]  = out_byte;
        2'd2:    size_acc_next[23:16] = out_byte;
        default: size_acc_next        = size_base;
      endcase
    end

    position_next = done ? 6'd0 : pos + 6'd1;

    res.out_byte        = out_byte;
    res.byte_position   = pos;
    res.field_kind      = kind;
    res.name_char_valid = (kind == KIND_NAME) && (out_byte != 8'd0);
    res.record_done     = done;
    res.entry_offset    = done ? offset_acc_next : 32'd0;
    res.entry_size      = done ? {out_byte, size_acc_next} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      offset_acc <= '0;
      size_acc   <= '0;
    end else if (ctrl.advance) begin
      position   <= position_next;
      offset_acc <= offset_acc_next;
      size_acc   <= size_acc_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lcgk_checker.sv @@
`default_nettype none

`include "lcg_keystream_header_cipher_macros.svh"

module lcgk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [7:0]  out_byte,
  input wire logic [5:0]  byte_position,
  input wire logic [1:0]  field_kind,
  input wire logic        name_char_valid,
  input wire logic        record_done,
  input wire logic [31:0] entry_offset,
  input wire logic [31:0] entry_size
);
  import lcgk_pkg::*;

  // Nothing is offered in the cycle after a reset.
  `LCGK_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !res_valid, "result valid after reset")

  `LCGK_ASSERT_ACTIVE(a_result_holds, res_valid && !res_ready |=> res_valid,
                      "result dropped while stalled")

  `LCGK_ASSERT_ACTIVE(a_done_at_end,
                      res_valid && record_done |->
                        byte_position == RecLast && field_kind == KIND_SIZE,
                      "record end away from the last size byte")

  `LCGK_ASSERT_ACTIVE(a_name_char,
                      res_valid && name_char_valid |->
                        field_kind == KIND_NAME && out_byte != 8'd0,
                      "name character flagged outside a nonzero name byte")

  `LCGK_ASSERT_ACTIVE(a_fields_only_at_end,
                      res_valid && !record_done |->
                        entry_offset == 32'd0 && entry_size == 32'd0,
                      "entry fields nonzero before record end")

endmodule

bind lcg_keystream_header_cipher lcgk_checker u_lcgk_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .out_byte        (result.out_byte),
  .byte_position   (result.byte_position),
  .field_kind      (result.field_kind),
  .name_char_valid (result.name_char_valid),
  .record_done     (result.record_done),
  .entry_offset    (result.entry_offset),
  .entry_size      (result.entry_size)
);

`default_nettype wire

@@ dv/lcgk_cipher_scoreboard.sv @@
`timescale 1ns / 100ps

// Watches the three channels, predicts every result from the accepted bytes
// and compares each result transfer with the oldest prediction.
module lcgk_cipher_scoreboard
  import lcgk_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  lcgk_item_if   item,
  lcgk_result_if result,
  lcgk_cfg_if    cfg,
  output int     fails,
  output int     pending
);

  localparam longint SchrageQ = 44488;
  localparam longint SchrageR = 3399;

  logic [15:0] seed_q;
  logic [30:0] key_q;
  logic [5:0]  pos_q;
  logic [31:0] offset_acc;
  logic [23:0] size_acc;
  result_t     expected_q[$];
  int          mismatch_count = 0;
  int          outstanding = 0;
  int          result_index = 0;

  assign fails   = mismatch_count;
  assign pending = outstanding;

  // Schrage's decomposition, kept literal: a key of 0 lands on 0x7FFFFFFF.
  function automatic logic [30:0] schrage_step(input logic [30:0] k);
    longint lo, hi, t;
    lo = longint'(k) % SchrageQ;
    hi = longint'(k) / SchrageQ;
    t  = longint'(KeyMult) * lo - SchrageR * hi;
    if (t <= 0) t += longint'(KeyMod);
    return t[30:0];
  endfunction

  task automatic crypt_byte(input logic [7:0] data, input logic rs);
    logic [7:0] ks;
    logic [7:0] ob;
    logic [5:0] pos;
    int         sh;
    result_t    want;
    if (rs) begin
      key_q      = {15'd0, seed_q};
      pos_q      = '0;
      offset_acc = '0;
      size_acc   = '0;
    end
    key_q = schrage_step(key_q);
    ks    = 8'(key_q % 31'(StreamMod));
    ob    = data ^ ks;
    pos   = (pos_q >= RecLen) ? 6'd0 : pos_q;

    want = '0;
    want.out_byte      = ob;
    want.byte_position = pos;
    if (pos < OffStart) begin
      want.field_kind = KIND_NAME;
    end else if (pos < SizeStart) begin
      want.field_kind = KIND_OFFSET;
      sh = 8 * (int'(pos) - int'(OffStart));
      offset_acc[sh +: 8] = ob;
    end else begin
      want.field_kind = KIND_SIZE;
      // The top size byte goes straight to the output on the last byte.
      if (pos < RecLast) begin
        sh = 8 * (int'(pos) - int'(SizeStart));
        size_acc[sh +: 8] = ob;
      end
    end
    want.name_char_valid = (want.field_kind == KIND_NAME) && (ob != 8'd0);
    want.record_done     = (pos == RecLast);
    if (want.record_done) begin
      want.entry_offset = offset_acc;
      want.entry_size   = {ob, size_acc};
    end
    pos_q = want.record_done ? 6'd0 : pos + 6'd1;
    expected_q.push_back(want);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
             $time, result_index, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      seed_q     = '0;
      key_q      = '0;
      pos_q      = '0;
      offset_acc = '0;
      size_acc   = '0;
      expected_q.delete();
    end else begin
      // The result side goes first so that a stray result is never matched
      // against a byte taken at the same edge.
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transfer, out_byte", 32'(result.out_byte), 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (result.out_byte !== want.out_byte)
            report("out_byte", 32'(result.out_byte), 32'(want.out_byte));
          if (result.byte_position !== want.byte_position)
            report("byte_position", 32'(result.byte_position), 32'(want.byte_position));
          if (result.field_kind !== want.field_kind)
            report("field_kind", 32'(result.field_kind), 32'(want.field_kind));
          if (result.name_char_valid !== want.name_char_valid)
            report("name_char_valid", 32'(result.name_char_valid),
                   32'(want.name_char_valid));
          if (result.record_done !== want.record_done)
            report("record_done", 32'(result.record_done), 32'(want.record_done));
          if (result.entry_offset !== want.entry_offset)
            report("entry_offset", result.entry_offset, want.entry_offset);
          if (result.entry_size !== want.entry_size)
            report("entry_size", result.entry_size, want.entry_size);
        end
        result_index++;
      end
      if (cfg.valid && cfg.ready) seed_q = cfg.seed;
      if (item.valid && item.ready) crypt_byte(item.data_byte, item.restart);
    end
    outstanding = expected_q.size();
  end

endmodule

@@ dv/tb_lcg_keystream_header_cipher.sv @@
`timescale 1ns / 100ps

module tb_lcg_keystream_header_cipher;
  import lcgk_pkg::*;

  localparam int WatchLimit = 2000;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 142;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic quiet = 1'b0;
  int   sent = 0;
  int   stuck_cycles = 0;
  int   fails;
  int   pending;

  lcgk_item_if   item_ch ();
  lcgk_result_if result_ch ();
  lcgk_cfg_if    cfg_ch ();

  lcg_keystream_header_cipher dut (
    .clk(clk), .rst(rst), .item(item_ch), .result(result_ch), .cfg(cfg_ch)
  );

  lcgk_cipher_scoreboard scoreboard (
    .clk(clk), .rst(rst), .item(item_ch), .result(result_ch), .cfg(cfg_ch),
    .fails(fails), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_ch.ready <= quiet || ($urandom_range(0, 99) >= 32);
  end

  // Ends the run when no channel has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchLimit) begin
      $display("[lcg_keystream_header_cipher] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    while (!quiet && $urandom_range(0, 99) < 32) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.data_byte <= b;
    item_ch.restart   <= rs;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Holds the input side until every predicted result has been seen.
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_seed(input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly whole records; now and then a record cut short by a restart,
  // or loose bytes with restarts scattered among them.
  task automatic send_burst(input bit first);
    int mode;
    int len;
    mode = $urandom_range(0, 99);
    if (mode < 80) begin
      for (int i = 0; i < int'(RecLen); i++)
        send_byte(8'($urandom_range(0, 255)), i == 0 && (first || $urandom_range(0, 3) == 0));
    end else if (mode < 90) begin
      len = $urandom_range(1, int'(RecLen) - 1);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
    end else begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    int target;
    bit first;
    item_ch.valid     = 1'b0;
    item_ch.data_byte = 8'd0;
    item_ch.restart   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.seed       = 16'd0;
    result_ch.ready   = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Straight out of reset the key is 0 and sticks at 0x7FFFFFFF, whose
    // stream byte is 0x7F, so the first byte decodes to an empty name char.
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    settle();
    write_seed(16'hFFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    settle();
    write_seed(16'h0001);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);

    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      quiet = (p == 5 || p == 6);
      case (p)
        0: begin
          write_seed(16'h0000);
        end
        1: begin
          write_seed(16'hFFFF);
        end
        2: begin
          write_seed(16'h0001);
        end
        default: begin
          write_seed(16'($urandom_range(0, 65535)));
        end
      endcase
      target = sent + PhaseItems;
      first  = 1'b1;
      while (sent < target) begin
        send_burst(first);
        first = 1'b0;
      end
    end
    settle();

    if (fails == 0) begin
      $display("[lcg_keystream_header_cipher] OK");
    end else begin
      $display("[lcg_keystream_header_cipher] ERROR");
    end
    $finish;
  end

endmodule
